FILE: src/nsy_pkg.sv
package nsy_pkg;

    // Fixed field widths of the ports and registers.
    localparam int IN_W       = 12;
    localparam int RATIO_W    = 24;
    localparam int DLS_W      = 13;
    localparam int SLS_W      = 14;
    localparam int OFF_W      = 25;
    localparam int PLANE_W    = 2;
    localparam int CMD_N      = 6;
    localparam int CMD_IDX_W  = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int SAT_IN_W   = 64;

    localparam logic [OFF_W-1:0] OFF_MAX = '1;

    // Register reset values.
    localparam logic [RATIO_W-1:0] RATIO_RST = RATIO_W'(65536);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_FMT   = 3'd0,
        REG_RATIO_W   = 3'd1,
        REG_RATIO_H   = 3'd2,
        REG_DST_LINE  = 3'd3,
        REG_SRC_LINE  = 3'd4,
        REG_RECT_X    = 3'd5,
        REG_RECT_Y    = 3'd6
    } t_cfg_reg;

    // Source layouts.
    localparam logic FMT_PLANAR = 1'b0;
    localparam logic FMT_YUYV   = 1'b1;

    // Plane codes.
    localparam logic [PLANE_W-1:0] PLANE_Y = 2'd0;
    localparam logic [PLANE_W-1:0] PLANE_U = 2'd1;
    localparam logic [PLANE_W-1:0] PLANE_V = 2'd2;

    // Command positions within the six commands of one item.
    localparam logic [CMD_IDX_W-1:0] CMD_Y00 = 3'd0;
    localparam logic [CMD_IDX_W-1:0] CMD_U   = 3'd4;
    localparam logic [CMD_IDX_W-1:0] CMD_V   = 3'd5;

    typedef struct packed {
        logic                 src_fmt;
        logic [RATIO_W-1:0]   ratio_w;
        logic [RATIO_W-1:0]   ratio_h;
        logic [DLS_W-1:0]     dst_line;
        logic [SLS_W-1:0]     src_line;
        logic [IN_W-1:0]      rect_x;
        logic [IN_W-1:0]      rect_y;
    } t_cfg;

    typedef struct packed {
        logic [CMD_N-1:0][OFF_W-1:0] src_off;
        logic [CMD_N-1:0][OFF_W-1:0] dst_off;
        logic [CMD_N-1:0]            oor;
    } t_cmd_set;

    typedef struct packed {
        logic             oor;
        logic [OFF_W-1:0] off;
    } t_sat;

    // Clamp an offset to the port width and flag when it did not fit.
    function automatic t_sat sat_off(input logic [SAT_IN_W-1:0] v);
        t_sat res;
        res.oor = |v[SAT_IN_W-1:OFF_W];
        res.off = res.oor ? OFF_MAX : v[OFF_W-1:0];
        return res;
    endfunction

endpackage

FILE: src/nsy_in_if.sv
interface nsy_in_if;
    logic                      valid;
    logic                      ready;
    logic [nsy_pkg::IN_W-1:0]  x_pos;
    logic [nsy_pkg::IN_W-1:0]  y_pos;

    modport source (output valid, output x_pos, output y_pos, input ready);
    modport sink   (input valid, input x_pos, input y_pos, output ready);
endinterface

FILE: src/nsy_out_if.sv
interface nsy_out_if;
    logic                         valid;
    logic                         ready;
    logic [nsy_pkg::PLANE_W-1:0]  dst_plane;
    logic [nsy_pkg::PLANE_W-1:0]  src_plane;
    logic [nsy_pkg::OFF_W-1:0]    src_offset;
    logic [nsy_pkg::OFF_W-1:0]    dst_offset;
    logic                         out_of_range;
    logic                         last;

    modport source (output valid, output dst_plane, output src_plane, output src_offset,
                    output dst_offset, output out_of_range, output last, input ready);
    modport sink   (input valid, input dst_plane, input src_plane, input src_offset,
                    input dst_offset, input out_of_range, input last, output ready);
endinterface

FILE: src/nearest_scale_to_yuv420p_unit.sv
// Nearest-neighbour scaler address engine for a planar YUV 4:2:0 destination. Each input
// item names one 2x2 block by its even position inside the destination rectangle, and the
// block answers with six copy commands in the order Y00, Y01, Y10, Y11, U, V; each command
// gives the source plane and byte offset to read and the destination plane and byte offset
// to write, with out_of_range raised when an offset had to be clamped to 25 bits. The
// source is planar 4:2:0 or packed YUYV, chosen by the source format register. An item
// passes three register stages (coordinate products, row products, offset sums) and lands
// in a six-command bank, from which its first command is offered. The command channel
// moves one command per cycle while the receiver is ready, so the drain of the command
// bank sets the sustained item rate. New items are taken while the bank drains, and up
// to three further items can wait in the stages behind it. Configuration is to be
// written only while no item is in flight.

module nearest_scale_to_yuv420p_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [nsy_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [nsy_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    nsy_in_if.sink                          i_item,
    nsy_out_if.source                       o_cmd
);

    // Configuration registers, written one at a time through the plain write port.
    nsy_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_fmt  <= nsy_pkg::FMT_PLANAR;
            r_cfg.ratio_w  <= nsy_pkg::RATIO_RST;
            r_cfg.ratio_h  <= nsy_pkg::RATIO_RST;
            r_cfg.dst_line <= '0;
            r_cfg.src_line <= '0;
            r_cfg.rect_x   <= '0;
            r_cfg.rect_y   <= '0;
        end else if (i_cfg_we) begin
            unique case (nsy_pkg::t_cfg_reg'(i_cfg_idx))
                nsy_pkg::REG_SRC_FMT: begin
                    r_cfg.src_fmt <= i_cfg_data[0];
                end
                nsy_pkg::REG_RATIO_W: begin
                    r_cfg.ratio_w <= i_cfg_data[nsy_pkg::RATIO_W-1:0];
                end
                nsy_pkg::REG_RATIO_H: begin
                    r_cfg.ratio_h <= i_cfg_data[nsy_pkg::RATIO_W-1:0];
                end
                nsy_pkg::REG_DST_LINE: begin
                    r_cfg.dst_line <= i_cfg_data[nsy_pkg::DLS_W-1:0];
                end
                nsy_pkg::REG_SRC_LINE: begin
                    r_cfg.src_line <= i_cfg_data[nsy_pkg::SLS_W-1:0];
                end
                nsy_pkg::REG_RECT_X: begin
                    r_cfg.rect_x <= i_cfg_data[nsy_pkg::IN_W-1:0];
                end
                nsy_pkg::REG_RECT_Y: begin
                    r_cfg.rect_y <= i_cfg_data[nsy_pkg::IN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // The arithmetic pipeline delivers all six offsets of an item at once.
    logic               calc_valid;
    logic               bank_free;
    nsy_pkg::t_cmd_set  calc_set;

    nsy_calc #(
        .FRAC_BITS (FRAC_BITS)
    ) u_calc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_item.valid),
        .o_ready (i_item.ready),
        .i_x     (i_item.x_pos),
        .i_y     (i_item.y_pos),
        .o_valid (calc_valid),
        .i_ready (bank_free),
        .o_set   (calc_set)
    );

    // The command bank holds one item's six commands and hands them out in order. It
    // refills in the same cycle that its last command, V, is taken, so the channel can
    // stay busy without a gap between items.
    nsy_pkg::t_cmd_set                   r_bank;
    logic                                r_bank_v;
    logic [nsy_pkg::CMD_IDX_W-1:0]       r_idx;
    logic                                cmd_take;
    logic                                at_last;

    assign at_last   = (r_idx == nsy_pkg::CMD_V);
    assign cmd_take  = r_bank_v && o_cmd.ready;
    assign bank_free = !r_bank_v || (o_cmd.ready && at_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_v <= 1'b0;
            r_idx    <= nsy_pkg::CMD_Y00;
        end else if (bank_free) begin
            r_bank_v <= calc_valid;
            r_idx    <= nsy_pkg::CMD_Y00;
        end else if (cmd_take) begin
            r_idx <= r_idx + nsy_pkg::CMD_IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (bank_free) begin
            r_bank <= calc_set;
        end
    end

    // Planes follow from the command position; a YUYV source is always read from plane 0.
    logic [nsy_pkg::PLANE_W-1:0] dst_plane;

    always_comb begin
        if (r_idx == nsy_pkg::CMD_U) begin
            dst_plane = nsy_pkg::PLANE_U;
        end else if (at_last) begin
            dst_plane = nsy_pkg::PLANE_V;
        end else begin
            dst_plane = nsy_pkg::PLANE_Y;
        end
    end

    assign o_cmd.valid        = r_bank_v;
    assign o_cmd.dst_plane    = dst_plane;
    assign o_cmd.src_plane    = (r_cfg.src_fmt == nsy_pkg::FMT_YUYV) ? nsy_pkg::PLANE_Y
                                                                     : dst_plane;
    assign o_cmd.src_offset   = r_bank.src_off[r_idx];
    assign o_cmd.dst_offset   = r_bank.dst_off[r_idx];
    assign o_cmd.out_of_range = r_bank.oor[r_idx];
    assign o_cmd.last         = at_last;

endmodule

FILE: src/nsy_calc.sv
module nsy_calc #(
    parameter int FRAC_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  nsy_pkg::t_cfg             i_cfg,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [nsy_pkg::IN_W-1:0]  i_x,
    input  logic [nsy_pkg::IN_W-1:0]  i_y,
    output logic                      o_valid,
    input  logic                      i_ready,
    output nsy_pkg::t_cmd_set         o_set
);

    localparam int PW   = nsy_pkg::IN_W + nsy_pkg::RATIO_W;
    localparam int YSW  = PW - FRAC_BITS;
    localparam int CW   = YSW + 1;
    localparam int COLW = CW + 1;
    localparam int PRW  = YSW + nsy_pkg::SLS_W;
    localparam int SSW  = PRW + 1;
    localparam int XDW  = nsy_pkg::IN_W + 1;
    localparam int YDLW = XDW + nsy_pkg::DLS_W;
    localparam int DSW  = YDLW + 2;

    // Stage enables: a stage takes new data when it is empty or its content moves on.
    logic en1, en2, en3;
    logic r_v1, r_v2, r_v3;

    assign en3     = !r_v3 || i_ready;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Stage 1: coordinate products and the destination row start.
    logic [nsy_pkg::IN_W-1:0] x_even, y_even;
    logic [XDW-1:0]           yd;
    logic [PW-1:0]            n_px, n_px1, n_py, n_py1;
    logic [XDW-1:0]           n_xd;
    logic [YDLW-1:0]          n_ydl;
    logic [PW-1:0]            r_px, r_px1, r_py, r_py1;
    logic [XDW-1:0]           r_xd;
    logic [YDLW-1:0]          r_ydl;

    always_comb begin
        x_even = {i_x[nsy_pkg::IN_W-1:1], 1'b0};
        y_even = {i_y[nsy_pkg::IN_W-1:1], 1'b0};
        n_px   = PW'(x_even) * PW'(i_cfg.ratio_w);
        n_px1  = PW'({x_even[nsy_pkg::IN_W-1:1], 1'b1}) * PW'(i_cfg.ratio_w);
        n_py   = PW'(y_even) * PW'(i_cfg.ratio_h);
        n_py1  = PW'({y_even[nsy_pkg::IN_W-1:1], 1'b1}) * PW'(i_cfg.ratio_h);
        n_xd   = XDW'(x_even) + XDW'({i_cfg.rect_x[nsy_pkg::IN_W-1:1], 1'b0});
        yd     = XDW'(y_even) + XDW'({i_cfg.rect_y[nsy_pkg::IN_W-1:1], 1'b0});
        n_ydl  = YDLW'(yd) * YDLW'(i_cfg.dst_line);
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_px  <= n_px;
            r_px1 <= n_px1;
            r_py  <= n_py;
            r_py1 <= n_py1;
            r_xd  <= n_xd;
            r_ydl <= n_ydl;
        end
    end

    // Stage 2: source row products, column terms and destination bases.
    logic [YSW-1:0]                       ys, ys2, xs, xs2;
    logic [CW-1:0]                        xy;
    logic [PRW-1:0]                       n_pa, n_pb, n_pc;
    logic [nsy_pkg::CMD_N-1:0][COLW-1:0]  n_col;
    logic [DSW-1:0]                       n_id, n_id1, n_idc;
    logic [PRW-1:0]                       r_pa, r_pb, r_pc;
    logic [nsy_pkg::CMD_N-1:0][COLW-1:0]  r_col;
    logic [DSW-1:0]                       r_id, r_id1, r_idc;

    always_comb begin
        ys   = YSW'(r_py >> FRAC_BITS);
        ys2  = YSW'(r_py1 >> FRAC_BITS);
        xs   = YSW'(r_px >> FRAC_BITS);
        xs2  = YSW'(r_px1 >> FRAC_BITS);
        xy   = CW'(r_px >> (FRAC_BITS - 1));
        n_pa = PRW'(ys) * PRW'(i_cfg.src_line);
        n_pb = PRW'(ys2) * PRW'(i_cfg.src_line);
        n_pc = PRW'(ys >> 1) * PRW'(i_cfg.src_line);
        if (i_cfg.src_fmt == nsy_pkg::FMT_YUYV) begin
            n_col[0] = COLW'(xy);
            n_col[1] = COLW'(xy) + COLW'(2);
            n_col[2] = COLW'(xy);
            n_col[3] = COLW'(xy) + COLW'(2);
            n_col[4] = COLW'(xy) + COLW'(1);
            n_col[5] = COLW'(xy) + COLW'(3);
        end else begin
            n_col[0] = COLW'(xs);
            n_col[1] = COLW'(xs2);
            n_col[2] = COLW'(xs);
            n_col[3] = COLW'(xs2);
            n_col[4] = COLW'(xs >> 1);
            n_col[5] = COLW'(xs >> 1);
        end
        // The destination column is even, so adding one only sets its low bit.
        n_id  = DSW'(r_xd) + DSW'(r_ydl);
        n_id1 = DSW'({r_xd[XDW-1:1], 1'b1}) + DSW'(r_ydl);
        n_idc = DSW'(r_xd >> 1) + DSW'(r_ydl >> 2);
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_pa  <= n_pa;
            r_pb  <= n_pb;
            r_pc  <= n_pc;
            r_col <= n_col;
            r_id  <= n_id;
            r_id1 <= n_id1;
            r_idc <= n_idc;
        end
    end

    // Stage 3: final offsets of all six commands, clamped to the port width.
    logic [PRW-1:0]     row;
    logic [SSW-1:0]     src_sum;
    logic [DSW-1:0]     dst_sum;
    nsy_pkg::t_sat      s_sat, d_sat;
    nsy_pkg::t_cmd_set  n_set;
    nsy_pkg::t_cmd_set  r_set;

    always_comb begin
        row     = '0;
        src_sum = '0;
        dst_sum = '0;
        s_sat   = '0;
        d_sat   = '0;
        n_set   = '0;
        for (int k = 0; k < nsy_pkg::CMD_N; k++) begin
            if (k < 2) begin
                row = r_pa;
            end else if (k < 4) begin
                row = r_pb;
            end else if (i_cfg.src_fmt == nsy_pkg::FMT_YUYV) begin
                row = r_pa;
            end else begin
                row = r_pc >> 1;
            end
            src_sum = SSW'(r_col[k]) + SSW'(row);
            if (k == 0) begin
                dst_sum = r_id;
            end else if (k == 1) begin
                dst_sum = r_id1;
            end else if (k == 2) begin
                dst_sum = r_id + DSW'(i_cfg.dst_line);
            end else if (k == 3) begin
                dst_sum = r_id1 + DSW'(i_cfg.dst_line);
            end else begin
                dst_sum = r_idc;
            end
            s_sat            = nsy_pkg::sat_off(nsy_pkg::SAT_IN_W'(src_sum));
            d_sat            = nsy_pkg::sat_off(nsy_pkg::SAT_IN_W'(dst_sum));
            n_set.src_off[k] = s_sat.off;
            n_set.dst_off[k] = d_sat.off;
            n_set.oor[k]     = s_sat.oor | d_sat.oor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_set <= n_set;
        end
    end

    assign o_set = r_set;

endmodule

FILE: src/nsy_chk.sv
module nsy_chk (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic                           i_ready,
    input  logic [nsy_pkg::PLANE_W-1:0]    i_dst_plane,
    input  logic [nsy_pkg::OFF_W-1:0]      i_src_offset,
    input  logic [nsy_pkg::OFF_W-1:0]      i_dst_offset,
    input  logic                           i_oor,
    input  logic                           i_last
);

    // A command that is offered and not taken stays, with its offsets and destination plane unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> (i_valid && $stable(i_src_offset)
                                   && $stable(i_dst_offset) && $stable(i_dst_plane)))
        else $error("command changed while stalled");

    // Only the V command closes an item.
    a_last_v: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_last) |-> (i_dst_plane == nsy_pkg::PLANE_V))
        else $error("last raised on a command other than V");

    // Once U is taken, V of the same item is offered in the very next cycle.
    a_u_then_v: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_ready && i_dst_plane == nsy_pkg::PLANE_U)
            |=> (i_valid && i_last && i_dst_plane == nsy_pkg::PLANE_V))
        else $error("V did not follow U");

    // An out-of-range command carries at least one clamped offset.
    a_oor_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_oor) |-> (i_src_offset == nsy_pkg::OFF_MAX
                                || i_dst_offset == nsy_pkg::OFF_MAX))
        else $error("out_of_range without a clamped offset");

endmodule

bind nearest_scale_to_yuv420p_unit nsy_chk u_nsy_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_cmd.valid),
    .i_ready      (o_cmd.ready),
    .i_dst_plane  (o_cmd.dst_plane),
    .i_src_offset (o_cmd.src_offset),
    .i_dst_offset (o_cmd.dst_offset),
    .i_oor        (o_cmd.out_of_range),
    .i_last       (o_cmd.last)
);
